@@ rtl/bipartite_maximum_matching_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the bipartite matching block
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BIPARTITE_MAXIMUM_MATCHING_ASSERT_SVH
`define BIPARTITE_MAXIMUM_MATCHING_ASSERT_SVH

// same-cycle implication
`define BMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bmm_pkg.sv @@
// ----------------------------------------------------------------------------
// bmm_pkg
// Shared types and constants of the bipartite matching block.
// ----------------------------------------------------------------------------
`default_nettype none

package bmm_pkg;

    localparam int LEFT_MAX_DEF  = 64;
    localparam int RIGHT_MAX_DEF = 64;
    localparam int FIELD_W       = 7;

    localparam logic REQ_EDGE    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_WR,
        ST_ROOT,
        ST_ROW,
        ST_SCAN,
        ST_OWN,
        ST_POP,
        ST_AUG,
        ST_EMIT
    } st_t;

    typedef struct packed {
        logic               valid;
        logic               req_type;
        logic [FIELD_W-1:0] left_vertex;
        logic [FIELD_W-1:0] right_vertex;
    } cmd_t;

    typedef struct packed {
        logic               valid;
        logic [FIELD_W-1:0] matching_size;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/bmm_ram.sv @@
// ----------------------------------------------------------------------------
// bmm_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/bmm_seq.sv @@
// ----------------------------------------------------------------------------
// bmm_seq
// Sequencer and bit-serial scan unit: edge loading, augmenting-path search
// on an explicit stack, result hand-off and the clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module bmm_seq #(
    parameter int LEFT_MAX  = bmm_pkg::LEFT_MAX_DEF,
    parameter int RIGHT_MAX = bmm_pkg::RIGHT_MAX_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire bmm_pkg::cmd_t               cmd,
    output logic                             cmd_ready,
    input  wire logic [bmm_pkg::FIELD_W-1:0] left_count,
    output bmm_pkg::res_t                    res,
    input  wire logic                        res_ready
);

    localparam int LW    = $clog2(LEFT_MAX + 1);   // left vertex, 0..LEFT_MAX
    localparam int LIDX  = $clog2(LEFT_MAX);       // row index
    localparam int IW    = $clog2(LEFT_MAX + 2);   // root counter
    localparam int SPW   = $clog2(LEFT_MAX + 1);   // stack depth
    localparam int RW    = $clog2(RIGHT_MAX + 2);  // scan position
    localparam int RIDX  = $clog2(RIGHT_MAX);      // column index
    localparam int SEW   = LW + RW;                // stack entry {lv, cand}
    localparam int CLR_N = (LEFT_MAX > RIGHT_MAX) ? LEFT_MAX : RIGHT_MAX;
    localparam int CW    = $clog2(CLR_N);
    localparam int FW    = bmm_pkg::FIELD_W;

    bmm_pkg::st_t state_reg, state_next;

    logic [IW-1:0]        i_reg, i_next;
    logic [LW-1:0]        limit_reg, limit_next;
    logic [SPW-1:0]       sp_reg, sp_next;
    logic [LIDX-1:0]      k_reg, k_next;
    logic [LW-1:0]        top_lv_reg, top_lv_next;
    logic [RW-1:0]        pos_reg, pos_next;
    logic [RW-1:0]        cand_reg, cand_next;
    logic [RIGHT_MAX-1:0] row_reg, row_next;
    logic [RIGHT_MAX-1:0] visited_reg, visited_next;
    logic [FW-1:0]        pair_reg, pair_next;
    logic [CW-1:0]        clr_reg, clr_next;
    logic                 edge_ok_reg, edge_ok_next;
    logic [LIDX-1:0]      edge_row_reg, edge_row_next;
    logic [RIDX-1:0]      edge_col_reg, edge_col_next;

    // memory ports
    logic                 adj_we;
    logic [LIDX-1:0]      adj_waddr, adj_raddr;
    logic [RIGHT_MAX-1:0] adj_wdata, adj_rdata;
    logic                 own_we;
    logic [RIDX-1:0]      own_waddr, own_raddr;
    logic [LW-1:0]        own_wdata, own_rdata;
    logic                 stk_we;
    logic [LIDX-1:0]      stk_waddr, stk_raddr;
    logic [SEW-1:0]       stk_wdata, stk_rdata;

    logic [LW-1:0]        stk_lv;
    logic [RW-1:0]        stk_cand;
    logic [RIDX-1:0]      j_idx;
    logic [RIGHT_MAX-1:0] row_set;

    assign stk_lv   = stk_rdata[SEW-1:RW];
    assign stk_cand = stk_rdata[RW-1:0];
    assign j_idx    = RIDX'(pos_reg - RW'(1));

    bmm_ram #(.WIDTH(RIGHT_MAX), .DEPTH(LEFT_MAX)) u_adj (
        .aclk(aclk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );

    bmm_ram #(.WIDTH(LW), .DEPTH(RIGHT_MAX)) u_owner (
        .aclk(aclk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
        .raddr(own_raddr), .rdata(own_rdata)
    );

    bmm_ram #(.WIDTH(SEW), .DEPTH(LEFT_MAX)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bmm_pkg::ST_CLEAR;
            clr_reg   <= '0;
            sp_reg    <= '0;
            i_reg     <= '0;
            pair_reg  <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            sp_reg    <= sp_next;
            i_reg     <= i_next;
            pair_reg  <= pair_next;
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg    <= limit_next;
        k_reg        <= k_next;
        top_lv_reg   <= top_lv_next;
        pos_reg      <= pos_next;
        cand_reg     <= cand_next;
        row_reg      <= row_next;
        visited_reg  <= visited_next;
        edge_ok_reg  <= edge_ok_next;
        edge_row_reg <= edge_row_next;
        edge_col_reg <= edge_col_next;
    end

    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        limit_next    = limit_reg;
        sp_next       = sp_reg;
        k_next        = k_reg;
        top_lv_next   = top_lv_reg;
        pos_next      = pos_reg;
        cand_next     = cand_reg;
        row_next      = row_reg;
        visited_next  = visited_reg;
        pair_next     = pair_reg;
        clr_next      = clr_reg;
        edge_ok_next  = edge_ok_reg;
        edge_row_next = edge_row_reg;
        edge_col_next = edge_col_reg;

        cmd_ready     = 1'b0;
        res.valid     = 1'b0;
        res.matching_size = pair_reg;

        row_set       = adj_rdata;
        row_set[edge_col_reg] = 1'b1;

        adj_we    = 1'b0;
        adj_waddr = edge_row_reg;
        adj_wdata = row_set;
        own_we    = 1'b0;
        own_waddr = RIDX'(cand_reg - RW'(1));
        own_wdata = top_lv_reg;
        own_raddr = j_idx;
        stk_we    = 1'b0;
        stk_waddr = LIDX'(sp_reg - SPW'(1));
        stk_wdata = {top_lv_reg, pos_reg};
        stk_raddr = LIDX'(sp_reg - SPW'(2));

        unique case (state_reg)
            bmm_pkg::ST_CLEAR: begin
                adj_we    = (32'(clr_reg) < LEFT_MAX);
                adj_waddr = LIDX'(clr_reg);
                adj_wdata = '0;
                own_we    = (32'(clr_reg) < RIGHT_MAX);
                own_waddr = RIDX'(clr_reg);
                own_wdata = '0;
                clr_next  = clr_reg + CW'(1);
                if (32'(clr_reg) == CLR_N - 1) begin
                    clr_next   = '0;
                    state_next = bmm_pkg::ST_IDLE;
                end
            end
            bmm_pkg::ST_IDLE: begin
                cmd_ready     = 1'b1;
                edge_ok_next  = (cmd.left_vertex != '0) && (cmd.right_vertex != '0)
                             && (32'(cmd.left_vertex) <= LEFT_MAX)
                             && (32'(cmd.right_vertex) <= RIGHT_MAX);
                edge_row_next = LIDX'(32'(cmd.left_vertex) - 32'd1);
                edge_col_next = RIDX'(32'(cmd.right_vertex) - 32'd1);
                if (cmd.valid) begin
                    if (cmd.req_type == bmm_pkg::REQ_COMPUTE) begin
                        limit_next = (32'(left_count) > LEFT_MAX) ? LW'(LEFT_MAX)
                                                                 : LW'(left_count);
                        i_next     = IW'(1);
                        pair_next  = '0;
                        state_next = bmm_pkg::ST_ROOT;
                    end else begin
                        state_next = bmm_pkg::ST_EDGE_WR;
                    end
                end
            end
            bmm_pkg::ST_EDGE_WR: begin
                // row read was issued on the accepting cycle
                adj_we     = edge_ok_reg;
                state_next = bmm_pkg::ST_IDLE;
            end
            bmm_pkg::ST_ROOT: begin
                if (32'(i_reg) > 32'(limit_reg)) begin
                    state_next = bmm_pkg::ST_EMIT;
                end else begin
                    visited_next = '0;
                    top_lv_next  = LW'(i_reg);
                    pos_next     = RW'(1);
                    sp_next      = SPW'(1);
                    state_next   = bmm_pkg::ST_ROW;
                end
            end
            bmm_pkg::ST_ROW: begin
                row_next   = adj_rdata;
                state_next = bmm_pkg::ST_SCAN;
            end
            bmm_pkg::ST_SCAN: begin
                if (32'(pos_reg) > RIGHT_MAX) begin
                    // top frame exhausted
                    if (sp_reg == SPW'(1)) begin
                        sp_next    = '0;
                        i_next     = i_reg + IW'(1);
                        state_next = bmm_pkg::ST_ROOT;
                    end else begin
                        sp_next    = sp_reg - SPW'(1);
                        state_next = bmm_pkg::ST_POP;
                    end
                end else if (row_reg[j_idx] && !visited_reg[j_idx]) begin
                    visited_next[j_idx] = 1'b1;
                    cand_next  = pos_reg;
                    pos_next   = pos_reg + RW'(1);
                    state_next = bmm_pkg::ST_OWN;
                end else begin
                    pos_next = pos_reg + RW'(1);
                end
            end
            bmm_pkg::ST_OWN: begin
                if (own_rdata == '0) begin
                    own_we = 1'b1;
                    if (sp_reg == SPW'(1)) begin
                        sp_next    = '0;
                        pair_next  = pair_reg + FW'(1);
                        i_next     = i_reg + IW'(1);
                        state_next = bmm_pkg::ST_ROOT;
                    end else begin
                        k_next     = LIDX'(sp_reg - SPW'(2));
                        state_next = bmm_pkg::ST_AUG;
                    end
                end else if (32'(sp_reg) < LEFT_MAX) begin
                    stk_we      = 1'b1;
                    stk_wdata   = {top_lv_reg, cand_reg};
                    top_lv_next = own_rdata;
                    pos_next    = RW'(1);
                    sp_next     = sp_reg + SPW'(1);
                    state_next  = bmm_pkg::ST_ROW;
                end else begin
                    // stack full: branch counts as failed
                    state_next = bmm_pkg::ST_SCAN;
                end
            end
            bmm_pkg::ST_POP: begin
                top_lv_next = stk_lv;
                pos_next    = stk_cand + RW'(1);
                state_next  = bmm_pkg::ST_ROW;
            end
            bmm_pkg::ST_AUG: begin
                // flip the matching along the path, one frame a cycle
                own_we    = 1'b1;
                own_waddr = RIDX'(stk_cand - RW'(1));
                own_wdata = stk_lv;
                stk_raddr = k_reg - LIDX'(1);
                if (k_reg == '0) begin
                    sp_next    = '0;
                    pair_next  = pair_reg + FW'(1);
                    i_next     = i_reg + IW'(1);
                    state_next = bmm_pkg::ST_ROOT;
                end else begin
                    k_next = k_reg - LIDX'(1);
                end
            end
            bmm_pkg::ST_EMIT: begin
                res.valid = 1'b1;
                if (res_ready) begin
                    pair_next  = '0;
                    clr_next   = '0;
                    state_next = bmm_pkg::ST_CLEAR;
                end
            end
            default: begin
                state_next = bmm_pkg::ST_CLEAR;
            end
        endcase

        adj_raddr = (state_reg == bmm_pkg::ST_IDLE) ? edge_row_next
                                                    : LIDX'(top_lv_next - LW'(1));
    end

    `include "bipartite_maximum_matching_assert.svh"

    `BMM_ASSERT_IMP(a_cmd_only_idle, cmd.valid, state_reg == bmm_pkg::ST_IDLE, "beat taken while busy")
    `BMM_ASSERT_IMP(a_sp_bound, state_reg == bmm_pkg::ST_SCAN, (sp_reg != '0) && (32'(sp_reg) <= LEFT_MAX), "stack pointer out of range")
    `BMM_ASSERT_NXT(a_emit_clear, (state_reg == bmm_pkg::ST_EMIT) && res_ready, state_reg == bmm_pkg::ST_CLEAR, "no clear after result")
    `BMM_ASSERT_IMP(a_aug_nonempty, state_reg == bmm_pkg::ST_AUG, 32'(sp_reg) >= 2, "augment walk on single frame")

endmodule

`default_nettype wire

@@ rtl/bipartite_maximum_matching.sv @@
// ----------------------------------------------------------------------------
// bipartite_maximum_matching
// Maximum bipartite matching size by augmenting-path search.
// ----------------------------------------------------------------------------
// Input beats on s_*: tuser = 0 loads edge (tdata left, right) into the
// adjacency RAM; tuser = 1 runs the search and returns one beat on m_*.
// Edge beats do a row read-modify-write on the adjacency RAM.
// A compute beat takes one root step per root plus, per search frame, a row
// read, one step per scanned column, an owner lookup per hit and a pop,
// plus one step per flipped frame. The column scan dominates its length.
// The result sits in an output register and the clear sweep goes on while
// m_tready is low; only a later result finding that register still full
// holds the search in its final state, with s_tready low.
// After each result, and after reset, a sweep over max(LEFT_MAX, RIGHT_MAX)
// addresses clears adjacency and matching RAMs; s_tready is low meanwhile.
// left_count is written on cfg_* (always ready) and kept across computes.
// aresetn is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module bipartite_maximum_matching #(
    parameter int LEFT_MAX  = bmm_pkg::LEFT_MAX_DEF,
    parameter int RIGHT_MAX = bmm_pkg::RIGHT_MAX_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // left_vertex[6:0], right_vertex[13:7]
    input  wire logic [0:0]  s_tuser,   // req_type[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // matching_size[6:0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [bmm_pkg::FIELD_W-1:0] cfg_data
);

    localparam int FW = bmm_pkg::FIELD_W;

    logic [FW-1:0] left_count_reg;
    logic          out_valid_reg;
    logic [FW-1:0] out_data_reg;
    logic          seq_ready;
    logic          res_ready;
    bmm_pkg::cmd_t cmd;
    bmm_pkg::res_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = seq_ready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {1'b0, out_data_reg};
    assign res_ready = !out_valid_reg || m_tready;

    assign cmd.valid        = s_tvalid && seq_ready;
    assign cmd.req_type     = s_tuser[0];
    assign cmd.left_vertex  = s_tdata[FW-1:0];
    assign cmd.right_vertex = s_tdata[2*FW-1:FW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                left_count_reg <= cfg_data;
            end
            if (res.valid && res_ready) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid && res_ready) begin
            out_data_reg <= res.matching_size;
        end
    end

    bmm_seq #(.LEFT_MAX(LEFT_MAX), .RIGHT_MAX(RIGHT_MAX)) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cmd_ready (seq_ready),
        .left_count(left_count_reg),
        .res       (res),
        .res_ready (res_ready)
    );

endmodule

`default_nettype wire
